// ===== rtl/lsdp_pkg.sv =====
// Shared types and constants for the LRU stack distance profiler.
`timescale 1ns / 1ps
`default_nettype none

package lsdp_pkg;

  localparam int DEF_STACK_CAPACITY = 64;
  localparam int DEF_COUNTER_BITS   = 32;

  localparam int TAG_W   = 64;
  localparam int OBJ_W   = 16;
  localparam int BLK_W   = 48;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 7;
  localparam int BIN_W   = 7;
  localparam int DEPTH_W = 7;
  localparam int OUT_W   = 32;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CACHE_ENTRIES = 1'b0;

  localparam logic [CFG_W-1:0] CACHE_ENTRIES_RST = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_HIT,
    ST_UPD,
    ST_CLR
  } lsdp_state_t;

  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } lsdp_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lsdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lsdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lsdp_cell.sv =====
// One stack cell: holds a tag, compares it, and takes its upper neighbor's tag on a shift.
`timescale 1ns / 1ps
`default_nettype none

module lsdp_cell
  import lsdp_pkg::*;
(
  input  wire logic           clk,
  input  wire lsdp_cell_ctl_t ctl,
  input  wire logic [TAG_W-1:0] prev_tag,
  input  wire logic [TAG_W-1:0] cmp_tag,
  output logic      [TAG_W-1:0] tag_o,
  output logic                  match_o
);

  logic [TAG_W-1:0] tag_r;
  logic             match_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      tag_r <= prev_tag;
    end
    match_r <= ctl.cmp_en && (tag_r == cmp_tag);
  end

  assign tag_o   = tag_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

// ===== rtl/lru_stack_distance_profiler.sv =====
// Top level of the LRU stack distance profiler: FSM, cell chain, histogram RAM, APB registers.
// Each access, bin read or unused opcode passes through compare, encode and histogram read, and
//   update and write back before its result is registered; a new item is taken only once the
//   last one is done and the output register is not stalled. A clear sweeps the histogram RAM
//   before its result.
// Reset: synchronous, active low; afterwards in_stall stays high for a histogram clearing
//   pass, one RAM entry per cycle. Register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module lru_stack_distance_profiler
  import lsdp_pkg::*;
#(
  parameter int STACK_CAPACITY = DEF_STACK_CAPACITY,
  parameter int COUNTER_BITS   = DEF_COUNTER_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    in_opcode,
  input  wire logic [OBJ_W-1:0]   in_object_id,
  input  wire logic [BLK_W-1:0]   in_block_number,
  input  wire logic [BIN_W-1:0]   in_bin_index,

  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic [DEPTH_W-1:0]      out_stack_depth,
  output logic                    out_evicted,
  output logic [OUT_W-1:0]        out_bin_count,
  output logic [OUT_W-1:0]        out_hit_count,
  output logic [OUT_W-1:0]        out_miss_count,

  // APB register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]        prdata,
  output logic                    pready
);

  // index into the stack / histogram, and a count that can reach the capacity
  localparam int IW   = $clog2(STACK_CAPACITY);
  localparam int CW   = $clog2(STACK_CAPACITY + 1);
  // compare width wide enough for both the count and the 7-bit register fields
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam int CXW  = (COUNTER_BITS > OUT_W) ? COUNTER_BITS : OUT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(STACK_CAPACITY - 1);

  // saturating increment of a statistics counter
  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // clamp a counter to the 32-bit result field
  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNTER_BITS-1:0] v);
    logic [CXW-1:0] ext;
    ext = CXW'(v);
    if (ext > CXW'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return ext[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  lsdp_state_t state_r, state_nxt;

  logic                    init_r;       // clearing pass is the one after reset
  logic [IW-1:0]           clr_cnt_r;
  logic [CFG_W-1:0]        cache_entries_r;
  logic [CW-1:0]           occ_r;
  logic [COUNTER_BITS-1:0] hit_tot_r, hit_tot_nxt;
  logic [COUNTER_BITS-1:0] miss_tot_r, miss_tot_nxt;

  // latched item
  logic [OP_W-1:0]         op_r;
  logic [TAG_W-1:0]        tag_r;
  logic [BIN_W-1:0]        bin_r;

  // lookup result
  logic                    hit_r;
  logic [IW-1:0]           pos_r;

  // output register
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [DEPTH_W-1:0]      out_depth_r;
  logic                    out_evicted_r;
  logic [OUT_W-1:0]        out_bin_r;
  logic [OUT_W-1:0]        out_hits_r;
  logic [OUT_W-1:0]        out_misses_r;

  logic accept;
  logic cfg_wr;
  logic upd_access;
  logic clr_done;

  // ---------------------------------------------------------------------------
  // Effective capacity: zero acts as one, clamp at the cell count
  // ---------------------------------------------------------------------------
  logic [CMPW-1:0] cap_ext;
  logic [CW-1:0]   cap;
  logic            full;

  always_comb begin
    cap_ext = (cache_entries_r == '0) ? CMPW'(1) : CMPW'(cache_entries_r);
    if (cap_ext > CMPW'(STACK_CAPACITY)) begin
      cap_ext = CMPW'(STACK_CAPACITY);
    end
    cap  = cap_ext[CW-1:0];
    full = (occ_r >= cap);
  end

  // bin read address; out-of-range bins read as zero
  logic [CMPW-1:0] bin_sum;
  logic [IW-1:0]   bin_addr;
  logic            bin_ok;

  assign bin_ok   = (bin_r != '0) && (CMPW'(bin_r) <= CMPW'(STACK_CAPACITY));
  assign bin_sum  = CMPW'(bin_r) - CMPW'(1);
  assign bin_addr = bin_sum[IW-1:0];

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the top of the stack
  // ---------------------------------------------------------------------------
  lsdp_cell_ctl_t         cell_ctl [STACK_CAPACITY];
  logic [TAG_W-1:0]       cell_tag [STACK_CAPACITY];
  logic [STACK_CAPACITY-1:0] match;
  logic [CW-1:0]          limit;   // deepest cell that takes its neighbor's tag

  always_comb begin
    if (hit_r) begin
      limit = CW'(pos_r);
    end else if (full) begin
      limit = cap - 1'b1;
    end else begin
      limit = occ_r;
    end
  end

  for (genvar g = 0; g < STACK_CAPACITY; g++) begin : g_cell
    logic [TAG_W-1:0] prev_tag;

    if (g == 0) begin : g_top
      assign prev_tag = tag_r;
    end else begin : g_below
      assign prev_tag = cell_tag[g-1];
    end

    assign cell_ctl[g].cmp_en   = (state_r == ST_CMP) && (op_r == OP_ACCESS) &&
                                  (CW'(g) < occ_r);
    assign cell_ctl[g].shift_en = upd_access && (CW'(g) <= limit);

    lsdp_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[g]),
      .prev_tag (prev_tag),
      .cmp_tag  (tag_r),
      .tag_o    (cell_tag[g]),
      .match_o  (match[g])
    );
  end

  // Valid tags are unique, so the match vector is one-hot or empty.
  logic [IW-1:0] pos_enc;
  logic          hit_enc;

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < STACK_CAPACITY; i++) begin
      if (match[i]) begin
        pos_enc = pos_enc | IW'(i);
      end
    end
    hit_enc = |match;
  end

  // ---------------------------------------------------------------------------
  // Depth histogram RAM
  // ---------------------------------------------------------------------------
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [COUNTER_BITS-1:0] ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [COUNTER_BITS-1:0] ram_rdata;

  lsdp_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (STACK_CAPACITY)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // FSM
  // ---------------------------------------------------------------------------
  assign clr_done = (state_r == ST_CLR) && (clr_cnt_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == OP_CLEAR) ? ST_CLR : ST_CMP;
        end
      end
      ST_CMP:  state_nxt = ST_HIT;
      ST_HIT:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      ST_CLR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The output register is free at the accepting edge, and one item is in
  // flight at a time, so a finished result never finds it occupied.
  always_comb begin
    in_stall   = 1'b1;
    upd_access = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = sat_inc(ram_rdata);
    ram_raddr  = pos_enc;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
      end
      ST_CMP: ;
      ST_HIT: begin
        ram_raddr = (op_r == OP_ACCESS) ? pos_enc : bin_addr;
      end
      ST_UPD: begin
        upd_access = (op_r == OP_ACCESS);
        ram_we     = (op_r == OP_ACCESS) && hit_r;
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    hit_tot_nxt  = hit_tot_r;
    miss_tot_nxt = miss_tot_r;
    if (upd_access) begin
      if (hit_r) begin
        hit_tot_nxt = sat_inc(hit_tot_r);
      end else begin
        miss_tot_nxt = sat_inc(miss_tot_r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLR;
      init_r          <= 1'b1;
      clr_cnt_r       <= '0;
      cache_entries_r <= CACHE_ENTRIES_RST;
      occ_r           <= '0;
      hit_tot_r       <= '0;
      miss_tot_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        cache_entries_r <= pwdata[CFG_W-1:0];
      end

      // histogram sweep
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_done ? '0 : clr_cnt_r + 1'b1;
        if (clr_done) begin
          init_r <= 1'b0;
        end
      end

      // a lowered capacity drops the surplus least recent entries
      if (accept && (in_opcode == OP_ACCESS) && (occ_r > cap)) begin
        occ_r <= cap;
      end
      if (upd_access && !hit_r) begin
        occ_r <= full ? cap : occ_r + 1'b1;
      end

      if (accept && (in_opcode == OP_CLEAR)) begin
        hit_tot_r  <= '0;
        miss_tot_r <= '0;
      end else begin
        hit_tot_r  <= hit_tot_nxt;
        miss_tot_r <= miss_tot_nxt;
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_UPD) || (clr_done && !init_r)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      tag_r <= {in_object_id, in_block_number};
      bin_r <= in_bin_index;
    end

    if (state_r == ST_HIT) begin
      hit_r <= hit_enc;
      pos_r <= pos_enc;
    end

    if (state_r == ST_UPD) begin
      out_hit_r     <= upd_access && hit_r;
      out_evicted_r <= upd_access && !hit_r && full;
      out_depth_r   <= (upd_access && hit_r) ? DEPTH_W'(CMPW'(pos_r) + CMPW'(1)) : '0;
      out_bin_r <= ((op_r == OP_READ) && bin_ok) ? sat_out(ram_rdata) : '0;
      out_hits_r   <= sat_out(hit_tot_nxt);
      out_misses_r <= sat_out(miss_tot_nxt);
    end else if (clr_done && !init_r) begin
      // a clear reports all zeros
      out_hit_r     <= 1'b0;
      out_evicted_r <= 1'b0;
      out_depth_r   <= '0;
      out_bin_r     <= '0;
      out_hits_r    <= '0;
      out_misses_r  <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_stack_depth = out_depth_r;
  assign out_evicted     = out_evicted_r;
  assign out_bin_count   = out_bin_r;
  assign out_hit_count   = out_hits_r;
  assign out_miss_count  = out_misses_r;

  // ---------------------------------------------------------------------------
  // APB registers: one register, writes to other indexes are dropped
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CACHE_ENTRIES);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CACHE_ENTRIES) begin
      prdata = APB_W'(cache_entries_r);
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_lru_stack_distance_profiler.sv =====
// Self-checking testbench for the LRU stack distance profiler: shadow LRU stack, random traffic.
`timescale 1ns / 1ps

module tb_lru_stack_distance_profiler;
  import lsdp_pkg::*;

  localparam int DEPTH_MAX = DEF_STACK_CAPACITY;
  localparam int POOL_SIZE = 100;
  localparam int RAND_PER_PHASE = 72;
  localparam int NUM_PHASES = 9;
  localparam int HOLDOFF_AT = 150;       // results seen before the long receiver hold-off
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;      // settling margin after the last result

  // opcode 3 has no meaning in the block; it only reports the totals
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // paddr[2] picks the register; the second slot is unmapped
  localparam logic [PADDR_W-1:0] ADDR_CACHE_ENTRIES = {REG_CACHE_ENTRIES, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [OBJ_W-1:0] object_id;
    logic [BLK_W-1:0] block_number;
    logic [BIN_W-1:0] bin_index;
  } lookup_req_t;

  typedef struct packed {
    logic               hit;
    logic [DEPTH_W-1:0] stack_depth;
    logic               evicted;
    logic [OUT_W-1:0]   bin_count;
    logic [OUT_W-1:0]   hit_count;
    logic [OUT_W-1:0]   miss_count;
  } depth_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = OP_ACCESS;
  logic [OBJ_W-1:0]    in_object_id = '0;
  logic [BLK_W-1:0]    in_block_number = '0;
  logic [BIN_W-1:0]    in_bin_index = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [DEPTH_W-1:0]  out_stack_depth;
  logic                out_evicted;
  logic [OUT_W-1:0]    out_bin_count;
  logic [OUT_W-1:0]    out_hit_count;
  logic [OUT_W-1:0]    out_miss_count;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]    pwdata = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  lru_stack_distance_profiler uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_object_id    (in_object_id),
    .in_block_number (in_block_number),
    .in_bin_index    (in_bin_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_stack_depth (out_stack_depth),
    .out_evicted     (out_evicted),
    .out_bin_count   (out_bin_count),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the profiler state. Updated at each accepted input transfer
  // and at each register write, so it always mirrors what the block should hold.
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0] shadow_stack [DEPTH_MAX];
  int               shadow_occ = 0;
  logic [OUT_W-1:0] shadow_hist [DEPTH_MAX];
  logic [OUT_W-1:0] shadow_hits = '0;
  logic [OUT_W-1:0] shadow_misses = '0;
  logic [CFG_W-1:0] shadow_entries = CACHE_ENTRIES_RST;

  lookup_req_t   access_backlog [$];   // items waiting for the driver
  depth_report_t pending_reports [$];  // predicted results, oldest first
  int            mismatches = 0;
  int            results_seen = 0;

  logic [TAG_W-1:0] tag_pool [POOL_SIZE];
  logic [TAG_W-1:0] last_tag = '0;

  initial begin
    for (int i = 0; i < DEPTH_MAX; i++) begin
      shadow_stack[i] = '0;
      shadow_hist[i] = '0;
    end
  end

  function automatic logic [OUT_W-1:0] sat_inc(logic [OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // 0 acts as 1, anything above the stack size acts as the stack size
  function automatic int live_capacity();
    int c;
    c = int'(shadow_entries);
    if (c == 0) c = 1;
    if (c > DEPTH_MAX) c = DEPTH_MAX;
    return c;
  endfunction

  function automatic depth_report_t lru_predict(lookup_req_t r);
    depth_report_t    rep;
    logic [TAG_W-1:0] tag;
    int               cap;
    int               pos;
    int               i;
    rep = '0;
    case (r.opcode)
      OP_ACCESS: begin
        tag = {r.object_id, r.block_number};
        cap = live_capacity();
        // capacity may have been lowered: drop the surplus tail quietly
        if (shadow_occ > cap) shadow_occ = cap;
        pos = -1;
        for (i = 0; i < shadow_occ; i++) begin
          if (pos < 0 && shadow_stack[i] == tag) pos = i;
        end
        if (pos >= 0) begin
          rep.hit = 1'b1;
          rep.stack_depth = DEPTH_W'(pos + 1);
          shadow_hits = sat_inc(shadow_hits);
          shadow_hist[pos] = sat_inc(shadow_hist[pos]);
          for (i = pos; i > 0; i--) shadow_stack[i] = shadow_stack[i-1];
          shadow_stack[0] = tag;
        end else begin
          shadow_misses = sat_inc(shadow_misses);
          if (shadow_occ >= cap) begin
            rep.evicted = 1'b1;
            shadow_occ = cap - 1;
          end
          for (i = shadow_occ; i > 0; i--) shadow_stack[i] = shadow_stack[i-1];
          shadow_stack[0] = tag;
          shadow_occ++;
        end
      end
      OP_READ: begin
        // bins are 1-based; 0 and anything past the stack read as zero
        if (r.bin_index >= 1 && r.bin_index <= DEPTH_MAX)
          rep.bin_count = shadow_hist[r.bin_index - 1];
      end
      OP_CLEAR: begin
        // statistics only, the stack survives a clear
        for (i = 0; i < DEPTH_MAX; i++) shadow_hist[i] = '0;
        shadow_hits = '0;
        shadow_misses = '0;
      end
      default: ;
    endcase
    rep.hit_count = shadow_hits;
    rep.miss_count = shadow_misses;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic lookup_req_t mk_req(logic [OP_W-1:0] op, logic [OBJ_W-1:0] obj,
                                         logic [BLK_W-1:0] blk, logic [BIN_W-1:0] bin);
    lookup_req_t r;
    r.opcode = op;
    r.object_id = obj;
    r.block_number = blk;
    r.bin_index = bin;
    return r;
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    return {$urandom(), $urandom()};
  endfunction

  // idle lengths: mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // Random item. Accesses dominate and mostly come from a window of the tag
  // pool a bit larger than the live capacity, so hits land at every depth and
  // misses keep evicting. The rest are fresh full-range tags, immediate re-references,
  // bin reads, clears and the unused opcode.
  function automatic lookup_req_t random_req();
    lookup_req_t      r;
    logic [TAG_W-1:0] tag;
    int               win;
    int               pick;
    tag = rand_tag();
    r = mk_req(OP_ACCESS, tag[TAG_W-1:BLK_W], tag[BLK_W-1:0], BIN_W'($urandom()));
    win = live_capacity() + live_capacity() / 4 + 2;
    if (win > POOL_SIZE) win = POOL_SIZE;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      tag = tag_pool[$urandom_range(0, win - 1)];
    end else if (pick < 78) begin
      tag = rand_tag();
    end else if (pick < 84) begin
      tag = last_tag;  // immediate re-reference, depth one
    end else if (pick < 94) begin
      r.opcode = OP_READ;
      if ($urandom_range(0, 9) < 7) r.bin_index = BIN_W'($urandom_range(1, 16));
    end else if (pick < 97) begin
      r.opcode = OP_CLEAR;
    end else begin
      r.opcode = OP_UNUSED;
    end
    if (r.opcode == OP_ACCESS) begin
      r.object_id = tag[TAG_W-1:BLK_W];
      r.block_number = tag[BLK_W-1:0];
      last_tag = tag;
    end
    return r;
  endfunction

  // APB write: setup cycle, then access cycle; shadow register follows at the write edge
  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_CACHE_ENTRIES) shadow_entries = data[CFG_W-1:0];
  endtask

  // idle = nothing queued, nothing offered, nothing outstanding; sampled on the
  // falling edge so every clocked update of the step has landed
  task automatic wait_drained();
    do @(negedge clk);
    while (access_backlog.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pops the backlog, holds the payload while stalled, and
  // predicts each item at the edge that accepts it.
  // ---------------------------------------------------------------------------
  int   gap_left = 0;
  logic tx_quiet = 1'b0;

  always @(posedge clk) begin : drive_in
    lookup_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        pending_reports.push_back(lru_predict(mk_req(in_opcode, in_object_id,
                                                     in_block_number, in_bin_index)));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (access_backlog.size() != 0) begin
          nxt = access_backlog.pop_front();
          in_opcode <= nxt.opcode;
          in_object_id <= nxt.object_id;
          in_block_number <= nxt.block_number;
          in_bin_index <= nxt.bin_index;
          in_valid <= 1'b1;
          // gap after this one is accepted; none during quiet stretches
          if (!tx_quiet && $urandom_range(0, 99) < 25) gap_left <= pick_len();
        end else begin
          in_valid <= 1'b0;
        end
        if ($urandom_range(0, 199) == 0) tx_quiet <= !tx_quiet;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random short/long stalls, quiet stretches, and one long
  // hold-off so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  int   holdoff_left = 0;
  logic holdoff_done = 1'b0;
  logic rx_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      holdoff_left <= 0;
    end else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      out_stall <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!rx_quiet && $urandom_range(0, 99) < 20) stall_left <= pick_len();
      if ($urandom_range(0, 149) == 0) rx_quiet <= !rx_quiet;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_out
    depth_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_reports.size() == 0) begin
        $error("result transfer with no prediction outstanding");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("hit", OUT_W'(want.hit), OUT_W'(out_hit));
        check_field("stack_depth", OUT_W'(want.stack_depth), OUT_W'(out_stack_depth));
        check_field("evicted", OUT_W'(want.evicted), OUT_W'(out_evicted));
        check_field("bin_count", want.bin_count, out_bin_count);
        check_field("hit_count", want.hit_count, out_hit_count);
        check_field("miss_count", want.miss_count, out_miss_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items at the reset capacity, then random phases
  // over a spread of capacity settings, each written while the block is idle.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cap_plan [NUM_PHASES] = '{7'd3, 7'd0, 7'd127, 7'd1, 7'd64,
                                              7'd100, 7'd5, 7'd16, 7'd2};
  localparam logic [OBJ_W-1:0] OBJ_MAX = '1;
  localparam logic [BLK_W-1:0] BLK_MAX = '1;

  initial begin : run_seq
    int ph;
    int n;
    for (n = 0; n < POOL_SIZE; n++) tag_pool[n] = rand_tag();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners; stack starts empty, capacity 64
    access_backlog.push_back(mk_req(OP_READ, '0, '0, 7'd1));         // empty histogram
    access_backlog.push_back(mk_req(OP_ACCESS, '0, '0, '0));         // miss
    access_backlog.push_back(mk_req(OP_ACCESS, OBJ_MAX, BLK_MAX, '1)); // miss, all ones
    access_backlog.push_back(mk_req(OP_ACCESS, '0, '0, '0));         // hit at depth two
    access_backlog.push_back(mk_req(OP_ACCESS, '0, '0, '0));         // hit at depth one
    access_backlog.push_back(mk_req(OP_ACCESS, OBJ_MAX, '0, '0));    // same block, other object
    access_backlog.push_back(mk_req(OP_ACCESS, '0, BLK_MAX, '0));    // same object, other block
    access_backlog.push_back(mk_req(OP_READ, '0, '0, 7'd0));         // bin zero reads zero
    access_backlog.push_back(mk_req(OP_READ, '0, '0, 7'd2));
    access_backlog.push_back(mk_req(OP_READ, '0, '0, 7'd1));
    access_backlog.push_back(mk_req(OP_READ, OBJ_MAX, BLK_MAX, 7'd64)); // deepest bin
    access_backlog.push_back(mk_req(OP_READ, '0, '0, 7'd65));        // past the stack
    access_backlog.push_back(mk_req(OP_READ, '0, '0, '1));
    access_backlog.push_back(mk_req(OP_UNUSED, OBJ_MAX, BLK_MAX, '1)); // totals only
    access_backlog.push_back(mk_req(OP_CLEAR, '0, '0, '0));
    access_backlog.push_back(mk_req(OP_READ, '0, '0, 7'd1));         // cleared bin
    access_backlog.push_back(mk_req(OP_ACCESS, OBJ_MAX, BLK_MAX, '0)); // stack kept over clear
    access_backlog.push_back(mk_req(OP_UNUSED, '0, '0, '0));
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // random upper bits: only the low seven belong to the register
      reg_write(ADDR_CACHE_ENTRIES, {(APB_W-CFG_W)'($urandom()), cap_plan[ph]});
      if (cap_plan[ph] == 7'd16) reg_write(ADDR_UNMAPPED, $urandom());
      for (n = 0; n < RAND_PER_PHASE; n++) access_backlog.push_back(random_req());
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_lru_stack_distance_profiler: clean");
    end else begin
      $display("tb_lru_stack_distance_profiler: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_lru_stack_distance_profiler: errors");
    $finish;
  end

endmodule
